[rtl/core/bta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

    // heap geometry
    localparam int HEAP_WORDS = 65536;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int WORD_W     = 32;
    localparam int PTR_W      = 34;
    localparam logic [WORD_W-1:0] HEAP_FREE_HDR = WORD_W'(0 - (HEAP_WORDS - 1));

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OOM  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] block_pointer;
        logic [18:0] byte_count;
    } t_in;

    typedef struct packed {
        logic [15:0] result_pointer;
        logic [1:0]  status;
        logic        moved;
        logic [15:0] copy_words;
    } t_out;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_FIT,
        ST_FIT_W,
        ST_MRG,
        ST_MRG_W,
        ST_MRG_END,
        ST_FIT_RB,
        ST_FIT_RBW,
        ST_SPL,
        ST_SPL_W,
        ST_SPL2,
        ST_SPL_DONE,
        ST_MV,
        ST_MV_W,
        ST_FREE,
        ST_FREE_W,
        ST_RA_W,
        ST_GR_NW,
        ST_GR_RB,
        ST_GR_RBW,
        ST_DONE
    } t_state;

    // where a merge walk returns to
    typedef enum logic [1:0] {
        RET_FIT,
        RET_SPLIT,
        RET_FREE,
        RET_GROW
    } t_ret;

endpackage

[rtl/core/bta_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/boundary_tag_heap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First fit word heap allocator with signed boundary tag headers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request (allocate, free, reallocate);
//   each request gives exactly one result on the output channel. Transfers
//   complete when valid is high and stall is low.
//   The block takes one request at a time. A request costs a heap RAM read
//   and a wait for its registered data per block header visited, plus the
//   header writes; an allocate walks the heap from the start, so its time
//   grows with fragmentation. The heap RAM port sets this.
//   After reset a clearing pass writes every heap word while input is
//   stalled; then the heap is one free block.
//   The result waits in an output register; a new request is taken while
//   the receiver stalls, and it completes once that register is free.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bta_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bta_pkg::t_out o_out_data
);

    localparam int AW = bta_pkg::ADDR_W;
    localparam int PW = bta_pkg::PTR_W;
    localparam int WW = bta_pkg::WORD_W;

    function automatic logic in_heap(input logic [PW-1:0] x);
        in_heap = (x != '0) && (x < PW'(bta_pkg::HEAP_WORDS));
    endfunction

    bta_pkg::t_state r_state, n_state;
    bta_pkg::t_ret   r_ret, n_ret;
    logic [1:0]      r_op, n_op;
    logic [15:0]     r_ptr, n_ptr;
    logic            r_bzero, n_bzero;
    logic [17:0]     r_words, n_words;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_q, n_q;
    logic [PW-1:0]   r_start, n_start;
    logic [WW-1:0]   r_cur, n_cur;
    logic [17:0]     r_sw, n_sw;
    logic [WW-1:0]   r_rest, n_rest;
    logic            r_valid, n_valid;
    logic            r_inalloc, n_inalloc;
    logic [15:0]     r_res, n_res;
    logic [1:0]      r_status, n_status;
    logic            r_moved, n_moved;
    logic [15:0]     r_copy, n_copy;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_ovalid, n_ovalid;
    bta_pkg::t_out   r_odata, n_odata;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [WW-1:0]   wr_data;
    logic [AW-1:0]   rd_addr;
    logic [WW-1:0]   rd_data;

    logic            hneg;
    logic [WW-1:0]   hmag;
    logic [PW-1:0]   hnext_p;
    logic [PW-1:0]   hnext_q;
    logic [PW-1:0]   total;
    logic [PW-1:0]   total_m;
    logic [PW-1:0]   nx_spl;
    logic [PW-1:0]   nx_ptr;
    logic [32:0]     grow_sum;
    logic [WW-1:0]   rest;
    logic [19:0]     bytes_up;
    logic            out_free;

    // heap memory
    bta_ram #(
        .WIDTH(WW),
        .DEPTH(bta_pkg::HEAP_WORDS)
    ) u_heap (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // header decode and pointer arithmetic
    assign hneg     = rd_data[WW-1];
    assign hmag     = hneg ? (WW'(0) - rd_data) : rd_data;
    assign hnext_p  = r_p + PW'(hmag) + PW'(1);
    assign hnext_q  = r_q + PW'(hmag) + PW'(1);
    assign total    = r_q - r_start;
    assign total_m  = PW'(1) - total;
    assign nx_spl   = r_p + PW'(r_sw) + PW'(1);
    assign nx_ptr   = PW'(r_ptr) + PW'(rd_data) + PW'(1);
    assign grow_sum = 33'(r_cur) + 33'(hmag) + 33'd1;
    assign rest     = hmag - WW'(r_words);
    assign bytes_up = 20'(i_in_data.byte_count) + 20'd3;
    assign out_free = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_state != bta_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bta_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ret     <= n_ret;
        r_op      <= n_op;
        r_ptr     <= n_ptr;
        r_bzero   <= n_bzero;
        r_words   <= n_words;
        r_p       <= n_p;
        r_q       <= n_q;
        r_start   <= n_start;
        r_cur     <= n_cur;
        r_sw      <= n_sw;
        r_rest    <= n_rest;
        r_valid   <= n_valid;
        r_inalloc <= n_inalloc;
        r_res     <= n_res;
        r_status  <= n_status;
        r_moved   <= n_moved;
        r_copy    <= n_copy;
        r_odata   <= n_odata;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_op      = r_op;
        n_ptr     = r_ptr;
        n_bzero   = r_bzero;
        n_words   = r_words;
        n_p       = r_p;
        n_q       = r_q;
        n_start   = r_start;
        n_cur     = r_cur;
        n_sw      = r_sw;
        n_rest    = r_rest;
        n_valid   = r_valid;
        n_inalloc = r_inalloc;
        n_res     = r_res;
        n_status  = r_status;
        n_moved   = r_moved;
        n_copy    = r_copy;
        n_clr     = r_clr;
        n_ovalid  = r_ovalid && i_out_stall;
        n_odata   = r_odata;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        rd_addr   = '0;

        unique case (r_state)
            bta_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == '0) ? bta_pkg::HEAP_FREE_HDR : '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(bta_pkg::HEAP_WORDS - 1)) begin
                    n_state = bta_pkg::ST_IDLE;
                end
            end

            bta_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_data.operation;
                    n_ptr     = i_in_data.block_pointer;
                    n_bzero   = (i_in_data.byte_count == '0);
                    n_words   = bytes_up[19:2];
                    n_res     = '0;
                    n_status  = bta_pkg::STAT_OK;
                    n_moved   = 1'b0;
                    n_copy    = '0;
                    n_valid   = 1'b0;
                    n_inalloc = 1'b0;
                    n_state   = bta_pkg::ST_START;
                end
            end

            bta_pkg::ST_START: begin
                case (r_op)
                    bta_pkg::OP_ALLOC: begin
                        if (r_bzero) begin
                            n_status = bta_pkg::STAT_ZERO;
                            n_state  = bta_pkg::ST_DONE;
                        end else begin
                            n_p       = PW'(1);
                            n_inalloc = 1'b1;
                            n_state   = bta_pkg::ST_FIT;
                        end
                    end
                    bta_pkg::OP_FREE: begin
                        n_p     = PW'(r_ptr);
                        n_state = bta_pkg::ST_FREE;
                    end
                    bta_pkg::OP_REALLOC: begin
                        if (r_bzero) begin
                            n_status = bta_pkg::STAT_ZERO;
                            n_p      = PW'(r_ptr);
                            n_state  = bta_pkg::ST_FREE;
                        end else if (in_heap(PW'(r_ptr))) begin
                            rd_addr = AW'(r_ptr - 16'd1);
                            n_state = bta_pkg::ST_RA_W;
                        end else begin
                            n_p       = PW'(1);
                            n_inalloc = 1'b1;
                            n_state   = bta_pkg::ST_FIT;
                        end
                    end
                    default: begin
                        n_state = bta_pkg::ST_DONE;
                    end
                endcase
            end

            // first fit: skip allocated blocks
            bta_pkg::ST_FIT: begin
                if (!in_heap(r_p)) begin
                    n_status = bta_pkg::STAT_OOM;
                    n_res    = '0;
                    n_state  = bta_pkg::ST_DONE;
                end else begin
                    rd_addr = AW'(r_p - PW'(1));
                    n_state = bta_pkg::ST_FIT_W;
                end
            end

            bta_pkg::ST_FIT_W: begin
                if (!hneg) begin
                    n_p     = hnext_p;
                    n_state = bta_pkg::ST_FIT;
                end else begin
                    n_start = r_p;
                    n_q     = r_p;
                    n_ret   = bta_pkg::RET_FIT;
                    n_state = bta_pkg::ST_MRG;
                end
            end

            // merge walk over a run of free blocks
            bta_pkg::ST_MRG: begin
                if (!in_heap(r_q)) begin
                    n_state = bta_pkg::ST_MRG_END;
                end else begin
                    rd_addr = AW'(r_q - PW'(1));
                    n_state = bta_pkg::ST_MRG_W;
                end
            end

            bta_pkg::ST_MRG_W: begin
                if (hneg) begin
                    n_q     = hnext_q;
                    n_state = bta_pkg::ST_MRG;
                end else begin
                    n_state = bta_pkg::ST_MRG_END;
                end
            end

            bta_pkg::ST_MRG_END: begin
                if (total != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_start - PW'(1));
                    wr_data = total_m[WW-1:0];
                end
                case (r_ret)
                    bta_pkg::RET_FIT:   n_state = bta_pkg::ST_FIT_RB;
                    bta_pkg::RET_SPLIT: n_state = bta_pkg::ST_SPL_DONE;
                    bta_pkg::RET_FREE:  n_state = bta_pkg::ST_DONE;
                    default:            n_state = bta_pkg::ST_GR_RB;
                endcase
            end

            // size check after a merge
            bta_pkg::ST_FIT_RB: begin
                rd_addr = AW'(r_p - PW'(1));
                n_state = bta_pkg::ST_FIT_RBW;
            end

            bta_pkg::ST_FIT_RBW: begin
                if (hmag >= WW'(r_words)) begin
                    n_state = bta_pkg::ST_SPL;
                end else begin
                    n_p     = hnext_p;
                    n_state = bta_pkg::ST_FIT;
                end
            end

            // split into allocated part and free remainder
            bta_pkg::ST_SPL: begin
                rd_addr = AW'(r_p - PW'(1));
                n_state = bta_pkg::ST_SPL_W;
            end

            bta_pkg::ST_SPL_W: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_p - PW'(1));
                if (rest == WW'(1)) begin
                    n_sw    = r_words + 18'd1;
                    n_rest  = '0;
                    wr_data = WW'(r_words + 18'd1);
                    n_state = bta_pkg::ST_SPL_DONE;
                end else begin
                    n_sw    = r_words;
                    n_rest  = rest;
                    wr_data = WW'(r_words);
                    n_state = (rest != '0) ? bta_pkg::ST_SPL2 : bta_pkg::ST_SPL_DONE;
                end
            end

            bta_pkg::ST_SPL2: begin
                if (nx_spl <= PW'(bta_pkg::HEAP_WORDS)) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(nx_spl - PW'(1));
                    wr_data = WW'(1) - r_rest;
                end
                n_start = nx_spl;
                n_q     = nx_spl;
                n_ret   = bta_pkg::RET_SPLIT;
                n_state = bta_pkg::ST_MRG;
            end

            bta_pkg::ST_SPL_DONE: begin
                n_res = r_p[15:0];
                if (r_inalloc && r_valid) begin
                    n_state = bta_pkg::ST_MV;
                end else begin
                    n_state = bta_pkg::ST_DONE;
                end
            end

            // moved block: report old size, then free it
            bta_pkg::ST_MV: begin
                rd_addr = AW'(r_ptr - 16'd1);
                n_state = bta_pkg::ST_MV_W;
            end

            bta_pkg::ST_MV_W: begin
                n_copy  = rd_data[15:0];
                n_moved = 1'b1;
                n_p     = PW'(r_ptr);
                n_state = bta_pkg::ST_FREE;
            end

            // free a block and merge what follows
            bta_pkg::ST_FREE: begin
                if (!in_heap(r_p)) begin
                    n_state = bta_pkg::ST_DONE;
                end else begin
                    rd_addr = AW'(r_p - PW'(1));
                    n_state = bta_pkg::ST_FREE_W;
                end
            end

            bta_pkg::ST_FREE_W: begin
                if (hneg) begin
                    n_state = bta_pkg::ST_DONE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_p - PW'(1));
                    wr_data = WW'(0) - rd_data;
                    n_start = r_p;
                    n_q     = r_p;
                    n_ret   = bta_pkg::RET_FREE;
                    n_state = bta_pkg::ST_MRG;
                end
            end

            // reallocate: keep, shrink or try to grow in place
            bta_pkg::ST_RA_W: begin
                if (hneg) begin
                    n_p       = PW'(1);
                    n_inalloc = 1'b1;
                    n_state   = bta_pkg::ST_FIT;
                end else begin
                    n_valid = 1'b1;
                    n_cur   = rd_data;
                    if (WW'(r_words) == rd_data) begin
                        n_res   = r_ptr;
                        n_state = bta_pkg::ST_DONE;
                    end else if (WW'(r_words) < rd_data) begin
                        n_p     = PW'(r_ptr);
                        n_state = bta_pkg::ST_SPL;
                    end else if (in_heap(nx_ptr)) begin
                        rd_addr = AW'(nx_ptr - PW'(1));
                        n_start = nx_ptr;
                        n_state = bta_pkg::ST_GR_NW;
                    end else begin
                        n_p       = PW'(1);
                        n_inalloc = 1'b1;
                        n_state   = bta_pkg::ST_FIT;
                    end
                end
            end

            bta_pkg::ST_GR_NW: begin
                if (hneg) begin
                    n_q     = r_start;
                    n_ret   = bta_pkg::RET_GROW;
                    n_state = bta_pkg::ST_MRG;
                end else begin
                    n_p       = PW'(1);
                    n_inalloc = 1'b1;
                    n_state   = bta_pkg::ST_FIT;
                end
            end

            bta_pkg::ST_GR_RB: begin
                rd_addr = AW'(r_start - PW'(1));
                n_state = bta_pkg::ST_GR_RBW;
            end

            bta_pkg::ST_GR_RBW: begin
                if (grow_sum >= 33'(r_words)) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_ptr - 16'd1);
                    wr_data = WW'(0) - grow_sum[WW-1:0];
                    n_p     = PW'(r_ptr);
                    n_state = bta_pkg::ST_SPL;
                end else begin
                    n_p       = PW'(1);
                    n_inalloc = 1'b1;
                    n_state   = bta_pkg::ST_FIT;
                end
            end

            // hand the result to the output register
            bta_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid                 = 1'b1;
                    n_odata.result_pointer   = r_res;
                    n_odata.status           = r_status;
                    n_odata.moved            = r_moved;
                    n_odata.copy_words       = r_copy;
                    n_state                  = bta_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bta_pkg::ST_IDLE;
            end
        endcase
    end

    // checks
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == bta_pkg::ST_START))
        else $error("accepted request did not start");

    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bta_pkg::ST_MRG_END) |-> (r_q >= r_start))
        else $error("merge walker behind its start");

    a_split_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bta_pkg::ST_SPL2) |-> (r_rest != '0))
        else $error("remainder split with no words");

    a_merge_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bta_pkg::ST_MRG_W) |->
        (r_q != '0 && r_q < PW'(bta_pkg::HEAP_WORDS)))
        else $error("merge read outside heap");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bta_pkg::ST_DONE && out_free) |=> r_ovalid)
        else $error("result not loaded");

endmodule
